// File: rtl/apa_pkg.sv
// ============================================================================
// Address pool allocator package
// Shared widths, status codes and the command and status bundles that pass
// between the allocator controller and its datapath.
// ============================================================================
package apa_pkg;

    // Tree geometry
    localparam int ADDR_BITS = 8;
    localparam int NLEAF     = 1 << ADDR_BITS;
    localparam int NODES     = 2 * NLEAF;        // heap slots 0..NODES-1, slot 0 unused
    localparam int HEAP_W    = ADDR_BITS + 1;    // heap index width
    localparam int CNT_W     = ADDR_BITS + 1;    // counts up to NLEAF
    localparam int STAT_W    = 2;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STAT_W + ADDR_BITS + CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Result status codes
    typedef logic [STAT_W-1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NONE     = 2'd1;
    localparam status_t ST_UNALLOC  = 2'd2;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Updates of the tree index register
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_ROOT,
        IDX_LEAF,
        IDX_HALF,
        IDX_DESC
    } idx_op_t;

    // Read address selection relative to the tree index
    typedef enum logic [1:0] {
        RD_IDX,
        RD_SIB,
        RD_LEFT
    } rd_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_req;
        idx_op_t idx_op;
        logic    rd_en;
        rd_op_t  rd_op;
        logic    wr_en;
        logic    wr_clear;
        logic    cur_and;
        logic    upd_start;
        logic    fail_none;
        logic    fail_unalloc;
        logic    out_load;
    } apa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic req_free;
        logic rdata;
        logic idx_root;
        logic idx_leaf;
        logic idx_odd;
        logic idx_last;
        logic out_busy;
    } apa_stat_t;

endpackage

// File: rtl/apa_datapath.sv
// ============================================================================
// Address pool allocator datapath
// Holds the full-flag tree memory, the tree index, the request, the used and
// capacity counters and the result register, all driven by controller commands.
// ============================================================================
module apa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  apa_pkg::apa_cmd_t             cmd,
    output apa_pkg::apa_stat_t            stat,
    input  logic                          in_req_type,
    input  logic [apa_pkg::ADDR_BITS-1:0] in_address,
    input  logic                          cfg_valid,
    input  logic [apa_pkg::CNT_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [apa_pkg::OUT_DATA_W-1:0] out_data
);
    import apa_pkg::*;

    // Full flags in heap order: internal nodes 1..NLEAF-1, leaves NLEAF..NODES-1
    logic                  tree_mem [0:NODES-1];
    logic                  rdata_reg;
    logic [HEAP_W-1:0]     rd_addr;
    logic                  wr_bit;

    logic [HEAP_W-1:0]     idx_reg,   idx_next;
    logic                  req_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic                  cur_reg;
    logic [ADDR_BITS-1:0]  gnt_reg;
    status_t               status_reg;
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      cap_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [CNT_W-1:0]      free_count;

    // Index update
    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_INC:  idx_next = idx_reg + HEAP_W'(1);
            IDX_ROOT: idx_next = HEAP_W'(1);
            IDX_LEAF: idx_next = {1'b1, addr_reg};
            IDX_HALF: idx_next = {1'b0, idx_reg[HEAP_W-1:1]};
            IDX_DESC: idx_next = {idx_reg[HEAP_W-2:0], rdata_reg};
            default:  idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // Memory read address relative to the current node
    always_comb
    begin
        case (cmd.rd_op)
            RD_IDX:  rd_addr = idx_reg;
            RD_SIB:  rd_addr = idx_reg ^ HEAP_W'(1);
            RD_LEFT: rd_addr = {idx_reg[HEAP_W-2:0], 1'b0};
            default: rd_addr = idx_reg;
        endcase
    end

    assign wr_bit = cmd.wr_clear ? 1'b0 : cur_reg;

    // Tree memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            tree_mem[idx_reg] <= wr_bit;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= tree_mem[rd_addr];
        end
    end

    // Request capture and per-request working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg  <= in_req_type;
            addr_reg <= in_address;
        end
        if (cmd.upd_start)
        begin
            cur_reg    <= (req_reg == REQ_ALLOC);
            gnt_reg    <= idx_reg[ADDR_BITS-1:0];
            status_reg <= ST_OK;
        end
        else if (cmd.cur_and)
        begin
            cur_reg <= cur_reg & rdata_reg;
        end
        if (cmd.fail_none)
        begin
            gnt_reg    <= '0;
            status_reg <= ST_NONE;
        end
        if (cmd.fail_unalloc)
        begin
            gnt_reg    <= idx_reg[ADDR_BITS-1:0];
            status_reg <= ST_UNALLOC;
        end
    end

    // Used count and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            cap_reg  <= CNT_W'(NLEAF);
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.upd_start)
            begin
                if (req_reg == REQ_ALLOC)
                begin
                    used_reg <= used_reg + CNT_W'(1);
                end
                else if (used_reg != '0)
                begin
                    used_reg <= used_reg - CNT_W'(1);
                end
            end
        end
    end

    assign free_count = (cap_reg > used_reg) ? (cap_reg - used_reg) : '0;

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= OUT_DATA_W'({free_count, gnt_reg, status_reg});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status toward the controller
    assign stat.req_free = (req_reg == REQ_FREE);
    assign stat.rdata    = rdata_reg;
    assign stat.idx_root = (idx_reg == HEAP_W'(1));
    assign stat.idx_leaf = idx_reg[HEAP_W-1];
    assign stat.idx_odd  = idx_reg[0];
    assign stat.idx_last = (idx_reg == HEAP_W'(NODES - 1));
    assign stat.out_busy = out_valid_reg & ~out_ready;

    // The used count can never pass the number of leaves
    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= CNT_W'(NLEAF))
        else $error("used count exceeds pool size");

    // A new result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten");

    // Tree updates never touch the unused heap slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && !cmd.wr_clear) |-> (idx_reg != '0))
        else $error("tree update at heap slot zero");

endmodule

// File: rtl/apa_ctrl.sv
// ============================================================================
// Address pool allocator controller
// One-hot state machine that clears the tree after reset and sequences the
// root check, the search for a free leaf and the walk that updates full flags.
// ============================================================================
module apa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  apa_pkg::apa_stat_t  stat,
    output apa_pkg::apa_cmd_t   cmd
);
    import apa_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_ROOT_RD  = 13'b0000000000100,
        S_ROOT_CHK = 13'b0000000001000,
        S_LEAF_RD  = 13'b0000000010000,
        S_LEAF_CHK = 13'b0000000100000,
        S_ASC      = 13'b0000001000000,
        S_ASC_CHK  = 13'b0000010000000,
        S_DSC_RD   = 13'b0000100000000,
        S_DSC_CHK  = 13'b0001000000000,
        S_UPD_WR   = 13'b0010000000000,
        S_UPD_CHK  = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.idx_op       = IDX_HOLD;
        cmd.rd_op        = RD_IDX;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_clear = 1'b1;
                cmd.idx_op   = IDX_INC;
                if (stat.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.idx_op   = IDX_ROOT;
                    state_next   = S_ROOT_RD;
                end
            end
            S_ROOT_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_ROOT_CHK;
            end
            S_ROOT_CHK:
            begin
                // A full tree rejects an allocation at once
                if (!stat.req_free && stat.rdata)
                begin
                    cmd.fail_none = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.idx_op = IDX_LEAF;
                    state_next = S_LEAF_RD;
                end
            end
            S_LEAF_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_LEAF_CHK;
            end
            S_LEAF_CHK:
            begin
                if (stat.req_free)
                begin
                    if (stat.rdata)
                    begin
                        cmd.upd_start = 1'b1;
                        state_next    = S_UPD_WR;
                    end
                    else
                    begin
                        cmd.fail_unalloc = 1'b1;
                        state_next       = S_DONE;
                    end
                end
                else if (!stat.rdata)
                begin
                    cmd.upd_start = 1'b1;
                    state_next    = S_UPD_WR;
                end
                else
                begin
                    state_next = S_ASC;
                end
            end
            S_ASC:
            begin
                // Climb until a right sibling has room
                if (stat.idx_root)
                begin
                    cmd.fail_none = 1'b1;
                    state_next    = S_DONE;
                end
                else if (!stat.idx_odd)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_op  = RD_SIB;
                    state_next = S_ASC_CHK;
                end
                else
                begin
                    cmd.idx_op = IDX_HALF;
                end
            end
            S_ASC_CHK:
            begin
                if (!stat.rdata)
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_DSC_RD;
                end
                else
                begin
                    cmd.idx_op = IDX_HALF;
                    state_next = S_ASC;
                end
            end
            S_DSC_RD:
            begin
                // Descend, preferring the left child when it has room
                if (stat.idx_leaf)
                begin
                    cmd.upd_start = 1'b1;
                    state_next    = S_UPD_WR;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_op  = RD_LEFT;
                    state_next = S_DSC_CHK;
                end
            end
            S_DSC_CHK:
            begin
                cmd.idx_op = IDX_DESC;
                state_next = S_DSC_RD;
            end
            S_UPD_WR:
            begin
                // Write the node, then fetch its sibling for the parent
                cmd.wr_en = 1'b1;
                if (stat.idx_root)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_op  = RD_SIB;
                    state_next = S_UPD_CHK;
                end
            end
            S_UPD_CHK:
            begin
                cmd.cur_and = 1'b1;
                cmd.idx_op  = IDX_HALF;
                state_next  = S_UPD_WR;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted request always starts with the root read
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_ROOT_RD))
        else $error("accepted request did not start at the root");

    // A result is only loaded on the way back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (state_reg == S_IDLE))
        else $error("result loaded outside completion");

    // Nothing is read from the tree while it is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!cmd.rd_en && !in_ready))
        else $error("tree accessed during clearing pass");

endmodule

// File: rtl/address_pool_allocator.sv
// ============================================================================
// Address pool allocator
// Grants the smallest free address at or above a requested one from a pool of
// 256 addresses, frees addresses, and reports the remaining free count.
// ============================================================================
// After reset the block clears every slot of its tree memory and holds
// s_axis_tready low; configuration writes are taken throughout. Requests are
// then handled one at a time by a walk over a binary tree of full flags kept
// in a single memory with one registered read and one write per cycle, so the
// time per request is set by the tree depth. A free of an address that is not
// allocated ends after the leaf check, and an allocation with the pool full
// ends after the root check. In the longest allocation the search climbs
// seven levels, crosses to the right sibling and descends seven levels, then
// nine flag writes follow on the way back up. The block returns to idle after
// the result load and only then accepts the next request.
// A finished result waits in an output register, and the next request is
// accepted while it does.
module address_pool_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [apa_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] address
    input  logic [0:0]                       s_axis_tuser,  // [0] req_type
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] status, [9:2] granted_address, [18:10] free_count
    output logic [apa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [apa_pkg::CNT_W-1:0]        cfg_data       // capacity
);
    import apa_pkg::*;

    apa_cmd_t  cmd;
    apa_stat_t stat;

    // Capacity can be written at any time
    assign cfg_ready = 1'b1;

    apa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    apa_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_req_type (s_axis_tuser[0]),
        .in_address  (s_axis_tdata[ADDR_BITS-1:0]),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule
